// ===== design/advert_duplicate_filter_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the advertising duplicate filter
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ADVERT_DUPLICATE_FILTER_CORE_ASSERT_SVH
`define ADVERT_DUPLICATE_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// The expression must hold at every clock edge outside reset.
`define ADF_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("advert duplicate filter: assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ADF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("advert duplicate filter: assertion failed");

`else

`define ADF_ASSERT(label, clk, rst, expr)
`define ADF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/adf_pkg.sv =====
// ---------------------------------------------------------------------------
// Advertising duplicate filter package
// Field widths and the types that travel along the cell chain.
// ---------------------------------------------------------------------------
`default_nettype none

package adf_pkg;

   localparam int TYPE_W = 2;
   localparam int ADDR_W = 48;
   localparam int TIME_W = 32;

   // A request as it moves from cell to cell, with the outcome gathered so far.
   typedef struct packed {
      logic [TYPE_W-1:0] addr_type;
      logic [ADDR_W-1:0] address;
      logic [TIME_W-1:0] sample_time;
      logic              found;     // some cell has claimed the request
      logic              dup;       // matching entry held the same timestamp
      logic              inserted;  // request was stored in a fresh entry
   } adf_probe_type;

   // Per-cell control from the top level.
   typedef struct packed {
      logic advance;  // chain moves this cycle
      logic live;     // this cell's entry has been written
      logic tail;     // this cell is the next one to fill
   } adf_cell_ctl_type;

endpackage

`default_nettype wire

// ===== design/advert_duplicate_filter_core.sv =====
// ---------------------------------------------------------------------------
// Advertising duplicate filter core
// Flags received packet reports whose device already sent the same timestamp.
// ---------------------------------------------------------------------------
// Usage:
// A request on the req_ channel carries an address type, a 48-bit device
// address and the sender's 32-bit timestamp. Each request yields exactly one
// response on the rsp_ channel: rsp_is_new is 0 when the device is known and
// its stored timestamp equals the new one, and 1 otherwise.
// The table is a row of TABLE_DEPTH cells, one entry each. An accepted request
// walks the row one cell per cycle unless the row is stalled; the first live
// cell that matches updates its timestamp, or the first unwritten cell stores
// the new device. A device seen with a full table is reported new and not stored.
// The request passes through each cell register in turn and then into the
// response register that drives rsp_valid. One request is in flight at a time,
// so a new request is taken only after the previous one leaves the row; req_ready
// returns as soon as the result enters the response register, even while that
// response still waits to be taken.
// A stalled receiver holds the response; a request that reaches the end of
// the row while the response register is still full waits there.
// Synchronous reset empties the table by clearing the fill count; the entries
// themselves are not cleared and req_ready stays low during reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "advert_duplicate_filter_core_assert.svh"

module advert_duplicate_filter_core #(
   parameter int TABLE_DEPTH = 10
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire [adf_pkg::TYPE_W-1:0] req_address_type,
   input  wire [adf_pkg::ADDR_W-1:0] req_device_address,
   input  wire [adf_pkg::TIME_W-1:0] req_sample_time,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic                      rsp_is_new
);

   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

   logic [FILL_W-1:0] fill_count_ff, fill_count_in;
   logic              busy_ff,       busy_in;
   logic              rsp_valid_ff,  rsp_valid_in;
   logic              rsp_is_new_ff, rsp_is_new_in;

   logic                   req_accept;
   logic                   stall;
   logic                   finish;
   adf_pkg::adf_probe_type entry_probe;

   // Chain links: index k feeds cell k, index TABLE_DEPTH is the row's output.
   logic                   link_valid [TABLE_DEPTH+1];
   adf_pkg::adf_probe_type link_probe [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0] cell_busy;

   assign req_ready  = !busy_ff && !reset;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      entry_probe.addr_type   = req_address_type;
      entry_probe.address     = req_device_address;
      entry_probe.sample_time = req_sample_time;
      entry_probe.found       = 1'b0;
      entry_probe.dup         = 1'b0;
      entry_probe.inserted    = 1'b0;
   end

   assign link_valid[0] = req_accept;
   assign link_probe[0] = entry_probe;

   // The whole row freezes only while a finished request waits at its end.
   assign stall  = link_valid[TABLE_DEPTH] && rsp_valid_ff && !rsp_ready;
   assign finish = link_valid[TABLE_DEPTH] && !stall;

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      adf_pkg::adf_cell_ctl_type ctl;

      always_comb begin
         ctl.advance = !stall;
         ctl.live    = FILL_W'(k) < fill_count_ff;
         ctl.tail    = FILL_W'(k) == fill_count_ff;
      end

      adf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .in_valid  (link_valid[k]),
         .in_probe  (link_probe[k]),
         .out_valid (link_valid[k+1]),
         .out_probe (link_probe[k+1])
      );

      assign cell_busy[k] = link_valid[k+1];
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_is_new_in = rsp_is_new_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end
      if (finish) begin
         busy_in       = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_is_new_in = !link_probe[TABLE_DEPTH].dup;
         if (link_probe[TABLE_DEPTH].inserted) begin
            fill_count_in = fill_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_is_new_ff <= rsp_is_new_in;
      if (reset) begin
         fill_count_ff <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_is_new = rsp_is_new_ff;

   // Only one request may be walking the row, and only while the core is busy.
   `ADF_ASSERT(a_single_request, clock, reset, $onehot0(cell_busy))
   `ADF_ASSERT(a_idle_row_empty, clock, reset, busy_ff || (cell_busy == '0))
   `ADF_ASSERT(a_fill_bound, clock, reset, fill_count_ff <= FILL_W'(TABLE_DEPTH))
   `ADF_ASSERT_NEXT(a_accept_enters, clock, reset, req_accept, link_valid[1] && busy_ff)

endmodule

`default_nettype wire

// ===== design/adf_cell.sv =====
// ---------------------------------------------------------------------------
// Duplicate filter cell
// Holds one table entry, checks the passing request against it and hands
// the request on to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module adf_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  adf_pkg::adf_cell_ctl_type ctl,
   input  wire                       in_valid,
   input  adf_pkg::adf_probe_type    in_probe,
   output logic                      out_valid,
   output adf_pkg::adf_probe_type    out_probe
);

   logic [adf_pkg::TYPE_W-1:0] entry_type_ff,    entry_type_in;
   logic [adf_pkg::ADDR_W-1:0] entry_address_ff, entry_address_in;
   logic [adf_pkg::TIME_W-1:0] entry_time_ff,    entry_time_in;
   logic                       probe_valid_ff,   probe_valid_in;
   adf_pkg::adf_probe_type     probe_ff,         probe_in;

   logic active;
   logic match;

   assign active = in_valid && ctl.advance && !in_probe.found;
   assign match  = ctl.live && (entry_type_ff == in_probe.addr_type)
                   && (entry_address_ff == in_probe.address);

   always_comb begin
      entry_type_in    = entry_type_ff;
      entry_address_in = entry_address_ff;
      entry_time_in    = entry_time_ff;
      probe_valid_in   = probe_valid_ff;
      probe_in         = probe_ff;
      if (ctl.advance) begin
         probe_valid_in = in_valid;
         probe_in       = in_probe;
      end
      if (active) begin
         if (match) begin
            probe_in.found = 1'b1;
            probe_in.dup   = (entry_time_ff == in_probe.sample_time);
            entry_time_in  = in_probe.sample_time;
         end else if (ctl.tail) begin
            probe_in.found    = 1'b1;
            probe_in.inserted = 1'b1;
            entry_type_in     = in_probe.addr_type;
            entry_address_in  = in_probe.address;
            entry_time_in     = in_probe.sample_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_type_ff    <= entry_type_in;
      entry_address_ff <= entry_address_in;
      entry_time_ff    <= entry_time_in;
      probe_ff         <= probe_in;
      if (reset) begin
         probe_valid_ff <= 1'b0;
      end else begin
         probe_valid_ff <= probe_valid_in;
      end
   end

   assign out_valid = probe_valid_ff;
   assign out_probe = probe_ff;

endmodule

`default_nettype wire

// ===== bench/advert_duplicate_filter_core_tb.sv =====
// ---------------------------------------------------------------------------
// Testbench for the advertising duplicate filter core
// Drives packet reports through the request channel and checks every
// response against its directed row or a bench table model. The run is a short
// directed part that fills the table to capacity, then random traffic aimed
// at stored devices, near misses and unknown devices. Both channels idle
// and stall at random, phase by phase.
// ---------------------------------------------------------------------------
module advert_duplicate_filter_core_tb;

   localparam int TABLE_DEPTH      = 10;
   localparam int DIRECTED_ROWS    = 19;
   localparam int RANDOM_PER_PHASE = 475;
   localparam int PHASES           = 4;
   // Cycles in which neither channel moves before the run is abandoned.
   localparam int QUIET_LIMIT      = 2000;
   // Settling time after the last response, a little over the walk latency.
   localparam int DRAIN_CYCLES     = TABLE_DEPTH + 4;

   typedef logic [adf_pkg::TYPE_W-1:0] addr_kind_type;
   typedef logic [adf_pkg::ADDR_W-1:0] dev_addr_type;
   typedef logic [adf_pkg::TIME_W-1:0] stamp_type;

   // One row of directed stimulus. When has_typed is set, the response is
   // the value given in the row; otherwise the table model decides it.
   typedef struct {
      addr_kind_type kind;
      dev_addr_type  addr;
      stamp_type     stamp;
      bit            has_typed;
      bit            typed_is_new;
   } directed_row_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   addr_kind_type req_address_type;
   dev_addr_type  req_device_address;
   stamp_type     req_sample_time;
   logic          rsp_valid;
   logic          rsp_ready;
   logic          rsp_is_new;

   // Table model of the seen devices.
   addr_kind_type seen_kind [TABLE_DEPTH];
   dev_addr_type  seen_addr [TABLE_DEPTH];
   stamp_type     seen_stamp[TABLE_DEPTH];
   int            seen_count;

   // Expected rsp_is_new values, oldest first.
   logic       pending_is_new[$];

   int         send_idle_pct;
   int         rsp_stall_pct;
   int         error_count;
   int         requests_sent;
   int         responses_seen;
   int         duplicates_seen;

   directed_row_type directed_rows[DIRECTED_ROWS];

   advert_duplicate_filter_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_address_type   (req_address_type),
      .req_device_address (req_device_address),
      .req_sample_time    (req_sample_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_new         (rsp_is_new)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Looks the device up in fill order. A matching entry with the same
   // timestamp is a duplicate; otherwise the timestamp is refreshed. An
   // unknown device is appended while there is room, and is new either way.
   function automatic logic classify_report(input addr_kind_type kind, input dev_addr_type addr,
                                            input stamp_type stamp);
      int k;
      for (k = 0; k < seen_count; k++) begin
         if (seen_kind[k] == kind && seen_addr[k] == addr) begin
            if (seen_stamp[k] == stamp) return 1'b0;
            seen_stamp[k] = stamp;
            return 1'b1;
         end
      end
      if (seen_count < TABLE_DEPTH) begin
         seen_kind[seen_count]  = kind;
         seen_addr[seen_count]  = addr;
         seen_stamp[seen_count] = stamp;
         seen_count++;
      end
      return 1'b1;
   endfunction

   // Offers one request, starting at a falling edge, and returns at the
   // falling edge after it was accepted.
   task automatic offer_request(input addr_kind_type kind, input dev_addr_type addr,
                                input stamp_type stamp, input bit has_typed,
                                input bit typed_is_new);
      logic model_is_new;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_address_type   <= kind;
      req_device_address <= addr;
      req_sample_time    <= stamp;
      do @(posedge clock); while (req_ready !== 1'b1);
      model_is_new = classify_report(kind, addr, stamp);
      pending_is_new.push_back(has_typed ? logic'(typed_is_new) : model_is_new);
      requests_sent++;
      @(negedge clock);
   endtask

   // Holds the sender back until every outstanding response has come, then
   // picks the idle and stall rates of the next phase.
   task automatic hold_until_drained(input int next_idle, input int next_stall);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_is_new.size() != 0);
      @(posedge clock);
      send_idle_pct = next_idle;
      rsp_stall_pct = next_stall;
      @(negedge clock);
   endtask

   // Most random reports hit a stored device, two thirds of them with its stored
   // timestamp. Some are near misses of a stored device, the rest are
   // entirely random.
   task automatic make_random_report(output addr_kind_type kind, output dev_addr_type addr,
                                     output stamp_type stamp);
      int pick;
      int k;
      pick = $urandom_range(99);
      k    = (seen_count > 0) ? $urandom_range(seen_count - 1) : 0;
      kind  = addr_kind_type'($urandom_range(3));
      addr  = {16'($urandom), 32'($urandom)};
      stamp = stamp_type'($urandom);
      if (seen_count > 0 && pick < 60) begin
         kind = seen_kind[k];
         addr = seen_addr[k];
         case ($urandom_range(2))
            0, 1:    stamp = seen_stamp[k];
            default: stamp = seen_stamp[k] ^ (stamp_type'(1) << $urandom_range(31));
         endcase
      end else if (seen_count > 0 && pick < 80) begin
         kind  = seen_kind[k];
         addr  = seen_addr[k];
         stamp = seen_stamp[k];
         if ($urandom_range(1)) addr = addr ^ (dev_addr_type'(1) << $urandom_range(47));
         else kind = kind ^ addr_kind_type'($urandom_range(1, 3));
      end
   endtask

   // The receiver stalls at the rate of the current phase.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Each accepted response is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         responses_seen++;
         if (rsp_is_new === 1'b0) duplicates_seen++;
         if (pending_is_new.size() == 0) begin
            $display("%0t: response with none expected, expected none, actual is_new %b",
                     $time, rsp_is_new);
            error_count++;
         end else begin
            if (rsp_is_new !== pending_is_new[0]) begin
               $display("%0t: is_new mismatch, expected %b, actual %b",
                        $time, pending_is_new[0], rsp_is_new);
               error_count++;
            end
            void'(pending_is_new.pop_front());
         end
      end
   end

   // Ends the run when neither channel has moved for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      addr_kind_type kind;
      dev_addr_type  addr;
      stamp_type     stamp;
      int            row;
      int            phase;
      int            n;
      int            idle_by_phase[PHASES];
      int            stall_by_phase[PHASES];

      reset              = 1'b1;
      req_valid          = 1'b0;
      req_address_type   = '0;
      req_device_address = '0;
      req_sample_time    = '0;
      rsp_ready          = 1'b0;
      send_idle_pct      = 0;
      rsp_stall_pct      = 0;
      seen_count         = 0;
      error_count        = 0;
      requests_sent      = 0;
      responses_seen     = 0;
      duplicates_seen    = 0;

      idle_by_phase  = '{0, 48, 0, 31};
      stall_by_phase = '{0, 0, 48, 31};

      // The first rows walk one device through store, duplicate and
      // refresh at the timestamp extremes. The same address under other
      // types must land in entries of its own. The table is then filled,
      // an unknown device is shown twice to prove it was not stored, and
      // the first and last entries are confirmed still in place.
      directed_rows = '{
         '{2'd0, 48'h0000_0000_0000, 32'h0000_0000, 1'b1, 1'b1},
         '{2'd0, 48'h0000_0000_0000, 32'h0000_0000, 1'b1, 1'b0},
         '{2'd0, 48'h0000_0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1},
         '{2'd0, 48'h0000_0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0},
         '{2'd3, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1},
         '{2'd3, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0},
         '{2'd1, 48'h0000_0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1},
         '{2'd3, 48'h0000_0000_0000, 32'h0000_0000, 1'b1, 1'b1},
         '{2'd2, 48'h0000_0000_0000, 32'h0000_0000, 1'b1, 1'b1},
         '{2'd0, 48'hFFFF_FFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1},
         '{2'd1, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0},
         '{2'd2, 48'h5555_5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0},
         '{2'd1, 48'h0000_0000_0001, 32'h8000_0000, 1'b0, 1'b0},
         '{2'd2, 48'h8000_0000_0000, 32'h0000_0001, 1'b0, 1'b0},
         '{2'd0, 48'h1234_5678_9ABC, 32'h0000_0005, 1'b1, 1'b1},
         '{2'd0, 48'h1234_5678_9ABC, 32'h0000_0005, 1'b1, 1'b1},
         '{2'd1, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0},
         '{2'd2, 48'h8000_0000_0000, 32'h0000_0001, 1'b0, 1'b0},
         '{2'd0, 48'h0000_0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         offer_request(directed_rows[row].kind, directed_rows[row].addr,
                       directed_rows[row].stamp, directed_rows[row].has_typed,
                       directed_rows[row].typed_is_new);
      end

      // Each random phase starts from an empty pipeline, so the sender has
      // paused for every outstanding response at least once.
      for (phase = 0; phase < PHASES; phase++) begin
         hold_until_drained(idle_by_phase[phase], stall_by_phase[phase]);
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            make_random_report(kind, addr, stamp);
            offer_request(kind, addr, stamp, 1'b0, 1'b0);
         end
      end

      hold_until_drained(0, 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d reports (%0d directed), got %0d responses, %0d of them duplicates.",
               requests_sent, DIRECTED_ROWS, responses_seen, duplicates_seen);
      $display("Traffic ran with a full table under %0d idle and stall phases.", PHASES);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
